[hdl/ffba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

    // Item kinds on the request channel.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NOFIT   = 2'd1,
        STATUS_BADFREE = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [14:0] request_bytes;
        logic [13:0] address;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [13:0] payload_address;
        logic [14:0] granted_bytes;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SRD,
        S_SEV,
        S_CRD,
        S_CEV,
        S_CSPLIT,
        S_CLAST,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

[hdl/ffba_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ffba_in_if;
    import ffba_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ffba_out_if;
    import ffba_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/ffba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/ffba_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl #(
    parameter int HEAP_BYTES   = 16384,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    ffba_in_if.sink             req,
    output ffba_pkg::out_item_t res,
    output logic                res_valid,
    input  wire logic           res_ready
);

    import ffba_pkg::*;

    localparam int SW = $clog2(HEAP_BYTES + 32768);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = 2 * SW + 1;
    localparam int AW = IW + 1;
    localparam logic [SW-1:0] HDR       = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CW-1:0] MAXC      = CW'(MAX_BLOCKS);

    state_t      state_reg, state_next;
    logic        bank_reg, bank_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] i_reg, i_next;
    logic [CW-1:0] wi_reg, wi_next;
    logic [IW-1:0] hit_reg, hit_next;
    logic        kind_reg, kind_next;
    logic [14:0] rq_reg, rq_next;
    logic [13:0] addr_reg, addr_next;
    logic        split_reg, split_next;
    logic [SW-1:0] rem_start_reg, rem_start_next;
    logic [SW-1:0] rem_size_reg, rem_size_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        pend_used_reg, pend_used_next;
    logic [SW-1:0] pend_start_reg, pend_start_next;
    logic [SW-1:0] pend_size_reg, pend_size_next;
    out_item_t   res_reg, res_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    // Two banks of the block table; each update copies one into the other.
    ffba_ram #(
        .WIDTH(EW),
        .DEPTH(2 ** AW)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Fields of the entry just read and the shared compare and add logic.
    logic [SW-1:0] cur_start, cur_size, need, pay_full, merged;
    logic          cur_used, last, fit, match, is_hit, cur_used_mod;

    assign cur_start    = ram_rdata[SW-1:0];
    assign cur_size     = ram_rdata[2*SW-1:SW];
    assign cur_used     = ram_rdata[2*SW];
    assign need         = SW'(rq_reg) + HDR;
    assign pay_full     = cur_start + HDR;
    assign merged       = pend_size_reg + cur_size + HDR;
    assign last         = (CW'(i_reg) == count_reg - CW'(1));
    assign fit          = !cur_used && (cur_size >= need);
    assign match        = cur_used && (pay_full == SW'(addr_reg));
    assign is_hit       = (i_reg == hit_reg);
    assign cur_used_mod = cur_used && !is_hit;

    assign res = res_reg;

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            bank_reg  <= 1'b0;
            count_reg <= CW'(1);
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        wi_reg         <= wi_next;
        hit_reg        <= hit_next;
        kind_reg       <= kind_next;
        rq_reg         <= rq_next;
        addr_reg       <= addr_next;
        split_reg      <= split_next;
        rem_start_reg  <= rem_start_next;
        rem_size_reg   <= rem_size_next;
        pend_valid_reg <= pend_valid_next;
        pend_used_reg  <= pend_used_next;
        pend_start_reg <= pend_start_next;
        pend_size_reg  <= pend_size_next;
        res_reg        <= res_next;
    end

    // Sequencer: search pass, then, for a successful request, copy pass into the other bank.
    always_comb
    begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        wi_next         = wi_reg;
        hit_next        = hit_reg;
        kind_next       = kind_reg;
        rq_next         = rq_reg;
        addr_next       = addr_reg;
        split_next      = split_reg;
        rem_start_next  = rem_start_reg;
        rem_size_next   = rem_size_reg;
        pend_valid_next = pend_valid_reg;
        pend_used_next  = pend_used_reg;
        pend_start_next = pend_start_reg;
        pend_size_next  = pend_size_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = {~bank_reg, wi_reg[IW-1:0]};
        ram_wdata       = ram_rdata;
        ram_raddr       = {bank_reg, i_reg};
        req.ready       = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                // Load the single free block that spans the heap.
                ram_we     = 1'b1;
                ram_waddr  = {1'b0, IW'(0)};
                ram_wdata  = {1'b0, INIT_SIZE, SW'(0)};
                bank_next  = 1'b0;
                count_next = CW'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    kind_next  = req.data.kind;
                    rq_next    = req.data.request_bytes;
                    addr_next  = req.data.address;
                    i_next     = '0;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                state_next = S_SEV;
            end
            S_SEV:
            begin
                if ((kind_reg == KIND_FREE) ? match : fit)
                begin
                    hit_next        = i_reg;
                    i_next          = '0;
                    wi_next         = '0;
                    pend_valid_next = 1'b0;
                    split_next      = 1'b0;
                    state_next      = S_CRD;
                    if (kind_reg == KIND_FREE)
                    begin
                        res_next = '{STATUS_OK, 14'd0, 15'd0};
                    end
                    else if (cur_size == need)
                    begin
                        res_next = '{STATUS_OK, pay_full[13:0], cur_size[14:0]};
                    end
                    else if (count_reg == MAXC)
                    begin
                        res_next   = '{STATUS_FULL, 14'd0, 15'd0};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        split_next     = 1'b1;
                        rem_start_next = cur_start + need;
                        rem_size_next  = cur_size - need;
                        res_next       = '{STATUS_OK, pay_full[13:0], rq_reg};
                    end
                end
                else if (last)
                begin
                    if (kind_reg == KIND_FREE)
                    begin
                        res_next = '{STATUS_BADFREE, 14'd0, 15'd0};
                    end
                    else
                    begin
                        res_next = '{STATUS_NOFIT, 14'd0, 15'd0};
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_SRD;
                end
            end
            S_CRD:
            begin
                state_next = S_CEV;
            end
            S_CEV:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    // Copy the entry, marking the granted one used.
                    ram_we  = 1'b1;
                    wi_next = wi_reg + CW'(1);
                    if (is_hit)
                    begin
                        ram_wdata = {1'b1, split_reg ? SW'(rq_reg) : cur_size, cur_start};
                    end
                    if (is_hit && split_reg)
                    begin
                        state_next = S_CSPLIT;
                    end
                    else if (last)
                    begin
                        count_next = wi_reg + CW'(1);
                        bank_next  = ~bank_reg;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_CRD;
                    end
                end
                else
                begin
                    // Merge adjacent free blocks into the pending entry.
                    pend_valid_next = 1'b1;
                    if (pend_valid_reg && !pend_used_reg && !cur_used_mod)
                    begin
                        pend_size_next = merged;
                    end
                    else
                    begin
                        if (pend_valid_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {pend_used_reg, pend_size_reg, pend_start_reg};
                            wi_next   = wi_reg + CW'(1);
                        end
                        pend_used_next  = cur_used_mod;
                        pend_start_next = cur_start;
                        pend_size_next  = cur_size;
                    end
                    if (last)
                    begin
                        state_next = S_CLAST;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_CRD;
                    end
                end
            end
            S_CSPLIT:
            begin
                // Free remainder goes right after the granted block.
                ram_we    = 1'b1;
                ram_wdata = {1'b0, rem_size_reg, rem_start_reg};
                wi_next   = wi_reg + CW'(1);
                if (last)
                begin
                    count_next = wi_reg + CW'(1);
                    bank_next  = ~bank_reg;
                    state_next = S_RESP;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_CRD;
                end
            end
            S_CLAST:
            begin
                ram_we     = 1'b1;
                ram_wdata  = {pend_used_reg, pend_size_reg, pend_start_reg};
                count_next = wi_reg + CW'(1);
                bank_next  = ~bank_reg;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(1)) && (count_reg <= MAXC))
        else $error("block count out of range");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.status != STATUS_OK) |->
        (res_reg.payload_address == 14'd0 && res_reg.granted_bytes == 15'd0))
        else $error("error result carries nonzero fields");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("ready stayed high after an accepted transfer");

    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> (state_reg == S_RESP))
        else $error("table bank changed outside a completed update");
`endif

endmodule

`default_nettype wire

[hdl/first_fit_block_allocator_top.sv]
// First-fit block allocator over a fixed heap, kept as an address-ordered
// table of blocks in a two-bank on-chip memory.
// The request channel carries kind (allocate or free), request_bytes and
// address; the response channel returns status, payload_address and
// granted_bytes, one response per request, in order.
// Each request first walks the table until a block fits or matches, then
// copies the whole table into the other bank, inserting a split remainder
// or merging free neighbors. An error response skips the copy pass.
// The sequencer takes one request at a time; ready is high only while idle.
// Responses sit in an output register, so the next request is taken while a
// finished response still waits for its transfer.
// After reset the block loads the initial heap block before ready rises.
// If the receiver stalls, the held response stays stable and the block stops
// after finishing at most one further request.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator_top #(
    parameter int HEAP_BYTES   = 16384,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 64
) (
    input wire logic   clk,
    input wire logic   rst_n,
    ffba_in_if.sink    req,
    ffba_out_if.source rsp
);

    import ffba_pkg::*;

    out_item_t res;
    logic      res_valid;
    logic      res_ready;
    logic      out_vld_reg;
    out_item_t out_data_reg;

    ffba_ctrl #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .res      (res),
        .res_valid(res_valid),
        .res_ready(res_ready)
    );

    // Output register between the sequencer and the response channel.
    assign res_ready = !out_vld_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_data_reg;

endmodule

`default_nettype wire

[verif/first_fit_block_allocator_top_tb.sv]
`timescale 1ns / 1ps

module first_fit_block_allocator_top_tb;
    import ffba_pkg::*;

    localparam int HEAP     = 16384;
    localparam int HDR      = 24;
    localparam int NBLK     = 64;
    localparam int WD_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    ffba_in_if  req ();
    ffba_out_if rsp ();

    first_fit_block_allocator_top #(
        .HEAP_BYTES(HEAP),
        .HEADER_BYTES(HDR),
        .MAX_BLOCKS(NBLK)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    always #4 clk = ~clk;

    // Shadow copy of the block table.
    int unsigned heap_start [NBLK];
    int unsigned heap_size [NBLK];
    bit          heap_used [NBLK];
    int unsigned heap_count;

    in_item_t  pending_items [$];
    out_item_t expected_rsp [$];
    int unsigned live_payloads [$];

    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    bit  hold_sender = 1'b0;
    bit  stimulus_done = 1'b0;
    int  mismatches = 0;
    int  quiet_cycles = 0;

    // Reset the shadow table to one free block covering the heap.
    function automatic void heap_reset();
        for (int k = 0; k < NBLK; k++)
        begin
            heap_start[k] = 0;
            heap_size[k] = 0;
            heap_used[k] = 1'b0;
        end
        heap_size[0] = HEAP - HDR;
        heap_count = 1;
    endfunction

    // Remove one table entry, shifting later entries down.
    function automatic void heap_drop(int unsigned idx);
        for (int unsigned k = idx; k + 1 < heap_count; k++)
        begin
            heap_start[k] = heap_start[k + 1];
            heap_size[k] = heap_size[k + 1];
            heap_used[k] = heap_used[k + 1];
        end
        heap_count--;
        heap_start[heap_count] = 0;
        heap_size[heap_count] = 0;
        heap_used[heap_count] = 1'b0;
    endfunction

    // Work out the response to one request and update the shadow table.
    function automatic out_item_t heap_apply(in_item_t it);
        out_item_t   r;
        int unsigned need;
        int unsigned hit;
        int unsigned i;
        bit          found;
        r.status = STATUS_OK;
        r.payload_address = '0;
        r.granted_bytes = '0;
        hit = heap_count;
        found = 1'b0;
        if (it.kind == KIND_ALLOC)
        begin
            need = it.request_bytes + HDR;
            for (i = 0; i < heap_count; i++)
            begin
                if (!heap_used[i] && heap_size[i] >= need)
                begin
                    hit = i;
                    break;
                end
            end
            if (hit >= heap_count)
                r.status = STATUS_NOFIT;
            else if (heap_size[hit] == need)
            begin
                heap_used[hit] = 1'b1;
                r.payload_address = 14'(heap_start[hit] + HDR);
                r.granted_bytes = 15'(heap_size[hit]);
            end
            else if (heap_count >= NBLK)
                r.status = STATUS_FULL;
            else
            begin
                for (i = heap_count; i > hit + 1; i--)
                begin
                    heap_start[i] = heap_start[i - 1];
                    heap_size[i] = heap_size[i - 1];
                    heap_used[i] = heap_used[i - 1];
                end
                heap_start[hit + 1] = heap_start[hit] + need;
                heap_size[hit + 1] = heap_size[hit] - need;
                heap_used[hit + 1] = 1'b0;
                heap_count++;
                heap_size[hit] = it.request_bytes;
                heap_used[hit] = 1'b1;
                r.payload_address = 14'(heap_start[hit] + HDR);
                r.granted_bytes = it.request_bytes;
            end
            if (r.status == STATUS_OK)
                live_payloads.push_back(r.payload_address);
        end
        else
        begin
            for (i = 0; i < heap_count; i++)
            begin
                if (heap_used[i] && heap_start[i] + HDR == it.address)
                begin
                    heap_used[i] = 1'b0;
                    found = 1'b1;
                    break;
                end
            end
            if (found)
            begin
                i = 0;
                while (i + 1 < heap_count)
                begin
                    if (!heap_used[i] && !heap_used[i + 1])
                    begin
                        heap_size[i] += heap_size[i + 1] + HDR;
                        heap_drop(i + 1);
                    end
                    else
                        i++;
                end
            end
            else
                r.status = STATUS_BADFREE;
        end
        return r;
    endfunction

    function automatic in_item_t make_item(bit kind, int unsigned bytes, int unsigned addr);
        in_item_t it;
        it.kind = kind;
        it.request_bytes = 15'(bytes);
        it.address = 14'(addr);
        return it;
    endfunction

    // Pick a free address: mostly a live payload, sometimes noise.
    function automatic int unsigned pick_free_addr();
        int unsigned n;
        n = live_payloads.size();
        if (n != 0 && $urandom_range(0, 99) < 85)
            return live_payloads[$urandom_range(0, n - 1)];
        return $urandom_range(0, 16383);
    endfunction

    // Request sizes are mostly small so that the table fills and splits often.
    function automatic int unsigned pick_bytes();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return $urandom_range(0, 200);
        if (p < 85)
            return $urandom_range(0, 1500);
        if (p < 95)
            return $urandom_range(0, 32767);
        return $urandom_range(16300, 16384);
    endfunction

    // Sender: takes items from the pending queue at random pace.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.data <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_rsp.push_back(heap_apply(req.data));
                void'(pending_items.pop_front());
            end
            if (!req.valid || req.ready)
            begin
                if (pending_items.size() > 0 && !hold_sender
                    && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    req.valid <= 1'b1;
                    req.data <= pending_items[0];
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random and checks every transfer.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected response transfer: %p", rsp.data);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.data.status !== want.status
                        || rsp.data.payload_address !== want.payload_address
                        || rsp.data.granted_bytes !== want.granted_bytes)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                want.status, want.payload_address, want.granted_bytes,
                                rsp.data.status, rsp.data.payload_address,
                                rsp.data.granted_bytes);
                    end
                end
            end
            rsp.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else if (!(stimulus_done && expected_rsp.size() == 0))
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || req.valid || expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        heap_reset();
        #1;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, exact fit, zero request, bad frees, full heap.
        pending_items.push_back(make_item(KIND_ALLOC, 0, 0));
        pending_items.push_back(make_item(KIND_FREE, 0, 24));
        pending_items.push_back(make_item(KIND_FREE, 0, 24));
        pending_items.push_back(make_item(KIND_ALLOC, 16384, 16383));
        pending_items.push_back(make_item(KIND_ALLOC, 32767, 0));
        pending_items.push_back(make_item(KIND_ALLOC, HEAP - 2 * HDR, 0));
        pending_items.push_back(make_item(KIND_ALLOC, 0, 0));
        pending_items.push_back(make_item(KIND_FREE, 0, 24));
        pending_items.push_back(make_item(KIND_ALLOC, 100, 0));
        pending_items.push_back(make_item(KIND_ALLOC, 200, 0));
        pending_items.push_back(make_item(KIND_ALLOC, 300, 0));
        pending_items.push_back(make_item(KIND_FREE, 0, 24 + 124));
        pending_items.push_back(make_item(KIND_ALLOC, 200 - HDR, 0));
        pending_items.push_back(make_item(KIND_FREE, 0, 16383));
        pending_items.push_back(make_item(KIND_FREE, 0, 24));
        pending_items.push_back(make_item(KIND_FREE, 0, 148));
        pending_items.push_back(make_item(KIND_FREE, 0, 372));
        pending_items.push_back(make_item(KIND_FREE, 0, 24));
        wait_drained();

        // Hold-off: the sender is held back before it offers the next item, then released.
        hold_sender = 1'b1;
        pending_items.push_back(make_item(KIND_ALLOC, 16383, 8191));
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();

        // Fill the table to the limit to reach the table-full case, then free all.
        for (int k = 0; k < NBLK + 2; k++)
            pending_items.push_back(make_item(KIND_ALLOC, $urandom_range(0, 60), 0));
        wait_drained();
        foreach (live_payloads[k])
            pending_items.push_back(make_item(KIND_FREE, 0, live_payloads[k]));
        wait_drained();

        // Random phases with different idling mixes.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0; sink_stall_pct = 0; end
                1: begin src_idle_pct = 59; sink_stall_pct = 0; end
                2: begin src_idle_pct = 0; sink_stall_pct = 59; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            for (n = 0; n < 175; n++)
            begin
                // Keep only a short lookahead so free addresses track live blocks.
                while (pending_items.size() > 1 || req.valid)
                    @(posedge clk);
                if ($urandom_range(0, 99) < 55)
                    pending_items.push_back(make_item(KIND_ALLOC, pick_bytes(),
                        $urandom_range(0, 16383)));
                else
                    pending_items.push_back(make_item(KIND_FREE, $urandom_range(0, 32767),
                        pick_free_addr()));
            end
            wait_drained();
        end

        stimulus_done = 1'b1;
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Freed payloads leave the live list.
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready && req.data.kind == KIND_FREE)
        begin
            for (int k = 0; k < live_payloads.size(); k++)
            begin
                if (live_payloads[k] == req.data.address)
                begin
                    live_payloads.delete(k);
                    break;
                end
            end
        end
    end

endmodule
